/* src/tot_pkg.sv */
package tot_pkg;

  // default sizes
  localparam int MAX_NODES_DEF = 64;
  localparam int COST_BITS_DEF = 24;

  // fixed field widths
  localparam int NODE_BITS = 6;
  localparam int TCOST_BITS = 30;
  localparam logic [TCOST_BITS-1:0] TOUR_SAT = '1;

  // input item modes
  localparam logic [1:0] MODE_COST  = 2'd0;
  localparam logic [1:0] MODE_TOUR  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_MAX_ITER   = 2'd1;

  typedef struct packed {
    logic [1:0]            mode;
    logic [NODE_BITS-1:0]  row_node;
    logic [NODE_BITS-1:0]  col_node;
    logic [23:0]           edge_cost;
    logic [NODE_BITS-1:0]  tour_position;
    logic [NODE_BITS-1:0]  tour_node;
    logic [TCOST_BITS-1:0] start_cost;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]  out_position;
    logic [NODE_BITS-1:0]  out_node;
    logic [TCOST_BITS-1:0] final_cost;
    logic                  last;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CPB, ST_RI, ST_RI1, ST_RJ, ST_RJN, ST_E0, ST_E1, ST_E2, ST_E3,
    ST_CMP, ST_DEC, ST_RV0, ST_RV1, ST_RV2, ST_RV3, ST_CT, ST_CN, ST_CW,
    ST_CMB, ST_CPW, ST_OR, ST_OL, ST_OV
  } state_t;

  // destination of tour data returning from the best tour memory
  typedef enum logic [2:0] {TD_NONE, TD_A, TD_B, TD_C, TD_D} tdst_t;

  // destination of cost data returning from the cost memory
  typedef enum logic [1:0] {CD_NONE, CD_OLD, CD_NEW, CD_SUM} cdst_t;

endpackage

/* src/tot_ram.sv */
module tot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/two_opt_tour_improver_top.sv */
// channel | direction | handshake        | payload
// in_     | input     | in_valid/in_stall   | in_item_t: load cost, load tour, start
// out_    | output    | out_valid/out_stall | out_item_t: one tour node per transaction
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a start runs a sequencer around reads of the cost memory through its one read port:
// copy the best tour to the work tour, scan edge pairs for the first improving one,
// reverse that segment by swaps, sum the closed-tour cost and compare, copy back when
// better. results leave one tour node at a time, each held while out_stall is high.
// rst_n is synchronous; memories hold no reset state and are not cleared by the block.
// in_stall is high for the whole search and output phase.
module two_opt_tour_improver_top
  import tot_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW  = IW + 1;
  localparam int CAW = $clog2(MAX_NODES * MAX_NODES);
  localparam int PW  = COST_BITS + 1;
  localparam int SW  = ((COST_BITS > TCOST_BITS) ? COST_BITS : TCOST_BITS) + 1;
  localparam logic [CW-1:0] N_MAX = CW'(MAX_NODES);

  function automatic logic [CAW-1:0] cost_addr(input logic [NODE_BITS-1:0] a,
                                               input logic [NODE_BITS-1:0] b);
    cost_addr = CAW'(int'(a) * MAX_NODES + int'(b));
  endfunction

  function automatic logic off_matrix(input logic [NODE_BITS-1:0] a,
                                      input logic [NODE_BITS-1:0] b);
    off_matrix = (int'(a) >= MAX_NODES) || (int'(b) >= MAX_NODES);
  endfunction

  state_t state_r, state_nxt;
  tdst_t  tdst_r, tdst_nxt;
  cdst_t  cdst_r, cdst_nxt;
  logic   czero_r, czero_nxt;
  logic [6:0]  node_count_r;
  logic [15:0] max_iter_r;
  logic [15:0] iter_r, iter_nxt;
  logic [TCOST_BITS-1:0] best_cost_r, best_cost_nxt;
  logic [TCOST_BITS-1:0] sum_r, sum_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, l_r, l_nxt, p_r, p_nxt;
  logic [NODE_BITS-1:0] ta_r, ta_nxt, tb_r, tb_nxt, tc_r, tc_nxt, td_r, td_nxt;
  logic [NODE_BITS-1:0] prev_r, prev_nxt;
  logic [PW-1:0] old_r, old_nxt, new_r, new_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic                 cost_we;
  logic [CAW-1:0]       cost_waddr, cost_raddr;
  logic [COST_BITS-1:0] cost_wdata, cost_rd, cval;
  logic                 best_we, work_we;
  logic [IW-1:0]        best_waddr, best_raddr, work_waddr, work_raddr;
  logic [NODE_BITS-1:0] best_wdata, best_rd, work_wdata, work_rd;
  logic [SW-1:0]        sum_add;
  logic [CW-1:0]        jn, n_clamp;

  tot_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(cost_raddr), .rdata(cost_rd)
  );
  tot_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_best (
    .clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
    .raddr(best_raddr), .rdata(best_rd)
  );
  tot_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_work (
    .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
    .raddr(work_raddr), .rdata(work_rd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cval    = czero_r ? '0 : cost_rd;
  assign sum_add = SW'(sum_r) + SW'(cval);
  assign jn      = (j_r + CW'(1) == n_r) ? '0 : j_r + CW'(1);
  assign n_clamp = (node_count_r < 7'd2) ? CW'(2) :
                   (32'(node_count_r) > 32'(MAX_NODES)) ? N_MAX : CW'(node_count_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd64;
      max_iter_r   <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_data[6:0];
        REG_MAX_ITER:   max_iter_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tdst_r      <= TD_NONE;
      cdst_r      <= CD_NONE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      best_cost_r <= '0;
    end else begin
      state_r     <= state_nxt;
      tdst_r      <= tdst_nxt;
      cdst_r      <= cdst_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
      best_cost_r <= best_cost_nxt;
    end
    czero_r <= czero_nxt;
    sum_r   <= sum_nxt;
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    l_r     <= l_nxt;
    p_r     <= p_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    tc_r    <= tc_nxt;
    td_r    <= td_nxt;
    prev_r  <= prev_nxt;
    old_r   <= old_nxt;
    new_r   <= new_nxt;
    out_r   <= out_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tdst_nxt      = TD_NONE;
    cdst_nxt      = CD_NONE;
    czero_nxt     = czero_r;
    iter_nxt      = iter_r;
    best_cost_nxt = best_cost_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    p_nxt         = p_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    tc_nxt        = tc_r;
    td_nxt        = td_r;
    prev_nxt      = prev_r;
    old_nxt       = old_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cost_we       = 1'b0;
    cost_waddr    = cost_addr(in_data.row_node, in_data.col_node);
    cost_wdata    = COST_BITS'(in_data.edge_cost);
    cost_raddr    = '0;
    best_we       = 1'b0;
    best_waddr    = IW'(in_data.tour_position);
    best_wdata    = in_data.tour_node;
    best_raddr    = '0;
    work_we       = 1'b0;
    work_waddr    = '0;
    work_wdata    = best_rd;
    work_raddr    = '0;

    // capture returning tour data
    unique case (tdst_r)
      TD_A:    ta_nxt = best_rd;
      TD_B:    tb_nxt = best_rd;
      TD_C:    tc_nxt = best_rd;
      TD_D:    td_nxt = best_rd;
      default: ;
    endcase

    // accumulate returning cost data
    unique case (cdst_r)
      CD_OLD:  old_nxt = old_r + PW'(cval);
      CD_NEW:  new_nxt = new_r + PW'(cval);
      CD_SUM:  sum_nxt = (sum_add > SW'(TOUR_SAT)) ? TOUR_SAT : sum_add[TCOST_BITS-1:0];
      default: ;
    endcase

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.mode)
            MODE_COST: begin
              cost_we = (int'(in_data.row_node) < MAX_NODES) &&
                        (int'(in_data.col_node) < MAX_NODES);
            end
            MODE_TOUR: begin
              best_we = (int'(in_data.tour_position) < MAX_NODES);
            end
            MODE_START: begin
              n_nxt         = n_clamp;
              best_cost_nxt = in_data.start_cost;
              iter_nxt      = '0;
              p_nxt         = '0;
              k_nxt         = '0;
              state_nxt     = (max_iter_r == '0) ? ST_OR : ST_CPB;
            end
            default: ;
          endcase
        end
      end

      // copy best tour into the work tour
      ST_CPB: begin
        best_raddr = p_r[IW-1:0];
        work_we    = (p_r != '0);
        work_waddr = IW'(p_r - CW'(1));
        work_wdata = best_rd;
        p_nxt      = p_r + CW'(1);
        if (p_r == n_r) begin
          i_nxt     = '0;
          j_nxt     = CW'(1);
          state_nxt = ST_RI;
        end
      end

      // fetch the nodes of edge i
      ST_RI: begin
        best_raddr = i_r[IW-1:0];
        tdst_nxt   = TD_A;
        state_nxt  = ST_RI1;
      end
      ST_RI1: begin
        best_raddr = IW'(i_r + CW'(1));
        tdst_nxt   = TD_B;
        state_nxt  = ST_RJ;
      end

      // fetch the nodes of edge j
      ST_RJ: begin
        best_raddr = j_r[IW-1:0];
        tdst_nxt   = TD_C;
        old_nxt    = '0;
        new_nxt    = '0;
        state_nxt  = ST_RJN;
      end
      ST_RJN: begin
        best_raddr = jn[IW-1:0];
        tdst_nxt   = TD_D;
        state_nxt  = ST_E0;
      end

      // edge lookups: a-b and c-d for the old pair, a-c and b-d for the reconnected pair
      ST_E0: begin
        cost_raddr = cost_addr(ta_r, tb_r);
        czero_nxt  = off_matrix(ta_r, tb_r);
        cdst_nxt   = CD_OLD;
        state_nxt  = ST_E1;
      end
      ST_E1: begin
        cost_raddr = cost_addr(ta_r, tc_r);
        czero_nxt  = off_matrix(ta_r, tc_r);
        cdst_nxt   = CD_NEW;
        state_nxt  = ST_E2;
      end
      ST_E2: begin
        cost_raddr = cost_addr(tc_r, td_r);
        czero_nxt  = off_matrix(tc_r, td_r);
        cdst_nxt   = CD_OLD;
        state_nxt  = ST_E3;
      end
      ST_E3: begin
        cost_raddr = cost_addr(tb_r, td_r);
        czero_nxt  = off_matrix(tb_r, td_r);
        cdst_nxt   = CD_NEW;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_DEC;
      end

      // first improving pair, else advance the scan, or sum the tour cost once the scan is done
      ST_DEC: begin
        if (new_r < old_r) begin
          k_nxt     = i_r + CW'(1);
          l_nxt     = j_r;
          state_nxt = ST_RV0;
        end else if (j_r + CW'(1) < n_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_RJ;
        end else if (i_r + CW'(2) < n_r) begin
          i_nxt     = i_r + CW'(1);
          j_nxt     = i_r + CW'(2);
          state_nxt = ST_RI;
        end else begin
          p_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = ST_CT;
        end
      end

      // reverse work tour positions k..l by swaps
      ST_RV0: begin
        work_raddr = k_r[IW-1:0];
        if (k_r < l_r) begin
          state_nxt = ST_RV1;
        end else begin
          p_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = ST_CT;
        end
      end
      ST_RV1: begin
        tc_nxt     = work_rd;
        work_raddr = l_r[IW-1:0];
        state_nxt  = ST_RV2;
      end
      ST_RV2: begin
        work_we    = 1'b1;
        work_waddr = k_r[IW-1:0];
        work_wdata = work_rd;
        state_nxt  = ST_RV3;
      end
      ST_RV3: begin
        work_we    = 1'b1;
        work_waddr = l_r[IW-1:0];
        work_wdata = tc_r;
        k_nxt      = k_r + CW'(1);
        l_nxt      = l_r - CW'(1);
        state_nxt  = ST_RV0;
      end

      // closed-tour cost of the work tour
      ST_CT: begin
        work_raddr = (p_r == n_r) ? '0 : p_r[IW-1:0];
        state_nxt  = ST_CN;
      end
      ST_CN: begin
        prev_nxt = work_rd;
        if (p_r != '0) begin
          cost_raddr = cost_addr(prev_r, work_rd);
          czero_nxt  = off_matrix(prev_r, work_rd);
          cdst_nxt   = CD_SUM;
        end
        if (p_r == n_r) begin
          state_nxt = ST_CW;
        end else begin
          p_nxt     = p_r + CW'(1);
          state_nxt = ST_CT;
        end
      end
      ST_CW: begin
        state_nxt = ST_CMB;
      end
      ST_CMB: begin
        p_nxt = '0;
        k_nxt = '0;
        if (sum_r < best_cost_r) begin
          best_cost_nxt = sum_r;
          state_nxt     = ST_CPW;
        end else begin
          state_nxt = ST_OR;
        end
      end

      // copy the accepted candidate back to the best tour
      ST_CPW: begin
        work_raddr = p_r[IW-1:0];
        best_we    = (p_r != '0);
        best_waddr = IW'(p_r - CW'(1));
        best_wdata = work_rd;
        p_nxt      = p_r + CW'(1);
        if (p_r == n_r) begin
          iter_nxt  = iter_r + 16'd1;
          p_nxt     = '0;
          state_nxt = (iter_r + 16'd1 < max_iter_r) ? ST_CPB : ST_OR;
        end
      end

      // emit the best tour, one node per transaction
      ST_OR: begin
        best_raddr = k_r[IW-1:0];
        state_nxt  = ST_OL;
      end
      ST_OL: begin
        out_nxt.out_position = NODE_BITS'(k_r);
        out_nxt.out_node     = best_rd;
        out_nxt.final_cost   = best_cost_r;
        out_nxt.last         = (k_r + CW'(1) == n_r);
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_OV;
      end
      ST_OV: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + CW'(1);
          state_nxt     = (k_r + CW'(1) == n_r) ? ST_IDLE : ST_OR;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tot_pkg::*;

  // tours only use a small pool of nodes whose pairwise costs are all loaded
  localparam int POOL_N = 12;

  // predicts the search and holds the tour nodes still to come out
  class TourSearchChecker;
    bit [23:0]         cost_mem [MAX_NODES_DEF*MAX_NODES_DEF];
    bit [NODE_BITS-1:0] best_tour [MAX_NODES_DEF];
    bit [6:0]          node_count = 7'd64;
    bit [15:0]         iter_limit = 16'd100;
    out_item_t         expected_q [$];
    int                errors = 0;

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == REG_NODE_COUNT) node_count = data[6:0];
      else if (idx == REG_MAX_ITER) iter_limit = data;
    endfunction

    function longint unsigned link_cost(bit [NODE_BITS-1:0] a, bit [NODE_BITS-1:0] b);
      return cost_mem[a * MAX_NODES_DEF + b];
    endfunction

    // closed tour length, clipped at the 30-bit ceiling after every add
    function longint unsigned tour_length(bit [NODE_BITS-1:0] t [MAX_NODES_DEF], int n);
      longint unsigned s;
      s = 0;
      for (int i = 0; i + 1 < n; i++) begin
        s += link_cost(t[i], t[i+1]);
        if (s > TOUR_SAT) s = TOUR_SAT;
      end
      s += link_cost(t[n-1], t[0]);
      if (s > TOUR_SAT) s = TOUR_SAT;
      return s;
    endfunction

    // first improving reversal applied to a copy of the best tour
    function void improve_once(ref bit [NODE_BITS-1:0] w [MAX_NODES_DEF], input int n);
      longint unsigned old_pair, new_pair;
      int jn, k, l;
      bit [NODE_BITS-1:0] t;
      w = best_tour;
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          jn = (j + 1 == n) ? 0 : j + 1;
          old_pair = link_cost(w[i], w[i+1]) + link_cost(w[j], w[jn]);
          new_pair = link_cost(w[i], w[j]) + link_cost(w[i+1], w[jn]);
          if (new_pair < old_pair) begin
            k = i + 1;
            l = j;
            while (k < l) begin
              t = w[k]; w[k] = w[l]; w[l] = t;
              k++; l--;
            end
            return;
          end
        end
      end
    endfunction

    function void note_input(in_item_t it);
      int n;
      longint unsigned best, c;
      bit [NODE_BITS-1:0] w [MAX_NODES_DEF];
      out_item_t r;
      case (it.mode)
        MODE_COST: cost_mem[it.row_node * MAX_NODES_DEF + it.col_node] = it.edge_cost;
        MODE_TOUR: best_tour[it.tour_position] = it.tour_node;
        MODE_START: begin
          n = node_count;
          if (n < 2) n = 2;
          if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
          best = it.start_cost;
          for (int k = 0; k < iter_limit; k++) begin
            improve_once(w, n);
            c = tour_length(w, n);
            if (c < best) begin
              best_tour = w;
              best = c;
            end else break;
          end
          for (int k = 0; k < n; k++) begin
            r.out_position = NODE_BITS'(k);
            r.out_node = best_tour[k];
            r.final_cost = TCOST_BITS'(best);
            r.last = (k + 1 == n);
            expected_q.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.out_position !== exp.out_position) begin
        $display("%0t: out_position exp %0d got %0d", $time,
                 exp.out_position, got.out_position);
        errors++;
      end
      if (got.out_node !== exp.out_node) begin
        $display("%0t: out_node exp %0d got %0d", $time, exp.out_node, got.out_node);
        errors++;
      end
      if (got.final_cost !== exp.final_cost) begin
        $display("%0t: final_cost exp %0d got %0d", $time,
                 exp.final_cost, got.final_cost);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last exp %0b got %0b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  TourSearchChecker board = new();
  int sent_count = 0;
  int hold_left = 0;

  two_opt_tour_improver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // result side: random stall, occasionally a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_data);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_left <= $urandom_range(10, 40);
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 40) begin
        out_stall <= 1'b0;
        hold_left <= 0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  // node number of pool entry k
  function automatic int pool_node(int k);
    return (k == POOL_N - 1) ? MAX_NODES_DEF - 1 : k * 5;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one input transaction, held until accepted
  task automatic send(in_item_t it, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    sent_count++;
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected tour node is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_item_t noise_item(logic [1:0] mode);
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  function automatic logic [23:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'hFFFFFF;
    if (r < 10) return 24'd0;
    if (r < 70) return 24'($urandom_range(1, 1000));
    return 24'($urandom);
  endfunction

  task automatic load_cost(int a, int b, logic [23:0] c, bit no_gap = 1'b0);
    in_item_t it;
    it = noise_item(MODE_COST);
    it.row_node = NODE_BITS'(a);
    it.col_node = NODE_BITS'(b);
    it.edge_cost = c;
    send(it, no_gap);
  endtask

  task automatic load_tour(int p, int v, bit no_gap = 1'b0);
    in_item_t it;
    it = noise_item(MODE_TOUR);
    it.tour_position = NODE_BITS'(p);
    it.tour_node = NODE_BITS'(v);
    send(it, no_gap);
  endtask

  task automatic start_search(logic [TCOST_BITS-1:0] sc);
    in_item_t it;
    it = noise_item(MODE_START);
    it.start_cost = sc;
    send(it);
  endtask

  // random run: usually a new tour on n positions, some cost edits, a start
  task automatic random_run(int n);
    int idx [POOL_N];
    int j, t, r, edits;
    for (int k = 0; k < POOL_N; k++) idx[k] = k;
    for (int k = POOL_N - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = idx[k]; idx[k] = idx[j]; idx[j] = t;
    end
    if ($urandom_range(0, 3) != 0)
      for (int k = 0; k < n; k++) load_tour(k, pool_node(idx[k % POOL_N]));
    edits = $urandom_range(0, 6);
    for (int k = 0; k < edits; k++)
      load_cost(pool_node($urandom_range(0, POOL_N-1)),
                pool_node($urandom_range(0, POOL_N-1)), pick_cost());
    if ($urandom_range(0, 9) == 0) send(noise_item(2'd3));
    r = $urandom_range(0, 9);
    if (r < 6) start_search(TOUR_SAT);
    else if (r < 7) start_search('0);
    else start_search(TCOST_BITS'($urandom));
  endtask

  initial begin
    int n, its, r, runs;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full pool matrix and tour so that no later read hits an unwritten entry
    write_cfg(REG_NODE_COUNT, 16'd64);
    write_cfg(REG_MAX_ITER, 16'd2);
    for (int a = 0; a < POOL_N; a++)
      for (int b = 0; b < POOL_N; b++)
        load_cost(pool_node(a), pool_node(b), pick_cost(), $urandom_range(0, 9) != 0);
    for (int k = 0; k < MAX_NODES_DEF; k++)
      load_tour(k, pool_node($urandom_range(0, POOL_N-1)));
    start_search(TOUR_SAT);
    drain();

    // directed: clamped counts, iteration extremes, cost extremes, odd modes
    write_cfg(REG_NODE_COUNT, 16'd0);
    write_cfg(REG_MAX_ITER, 16'hFFFF);
    load_cost(63, 0, 24'hFFFFFF);
    load_cost(0, 63, 24'd0);
    load_tour(0, 63);
    load_tour(1, 0);
    start_search(TOUR_SAT);
    send(noise_item(2'd3));
    start_search('0);
    drain();
    write_cfg(REG_NODE_COUNT, 16'd1);
    load_cost(63, 63, 24'hFFFFFF);
    load_cost(0, 0, 24'd0);
    load_tour(63, 63);
    start_search(TCOST_BITS'($urandom));
    drain();
    write_cfg(REG_NODE_COUNT, 16'd127);
    write_cfg(REG_MAX_ITER, 16'd0);
    start_search(TOUR_SAT);
    drain();
    write_cfg(REG_NODE_COUNT, 16'd3);
    write_cfg(REG_MAX_ITER, 16'hFFFF);
    load_tour(0, 5); load_tour(1, 10); load_tour(2, 15);
    start_search(TOUR_SAT);
    drain();
    write_cfg(REG_NODE_COUNT, 16'd64);
    write_cfg(REG_MAX_ITER, 16'd1);
    start_search(TOUR_SAT);
    drain();

    // random phases
    while (sent_count < 360) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(2, 10);
      else if (r < 80) n = $urandom_range(0, 1);
      else if (r < 90) n = $urandom_range(11, 24);
      else n = $urandom_range(64, 127);
      write_cfg(REG_NODE_COUNT, 16'(n));
      if (n < 2) n = 2;
      if (n > 64) n = 64;
      r = $urandom_range(0, 99);
      if (r < 5 && n <= 4) its = 16'hFFFF;
      else if (n > 10) its = $urandom_range(0, 2);
      else its = $urandom_range(0, 8);
      write_cfg(REG_MAX_ITER, 16'(its));
      runs = $urandom_range(1, 4);
      for (int k = 0; k < runs; k++) begin
        random_run(n);
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    drain();
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
